// ===== design/ip_address_to_text_assert.svh =====
// ----------------------------------------------------------------------------
// ip_address_to_text assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TO_TEXT_ASSERT_SVH
`define IP_ADDRESS_TO_TEXT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define IPAT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IPAT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ipat_pkg.sv =====
// ----------------------------------------------------------------------------
// ipat_pkg
// codes, character constants and digit helpers for ip_address_to_text
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipat_pkg;

    localparam logic [1:0] OP_IPV4    = 2'd0;
    localparam logic [1:0] OP_IPV6    = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // what the text cursor points at
    typedef enum logic [1:0] {
        K_DIG,
        K_SEP,
        K_ZA,
        K_ZB
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] grp;
        logic [1:0] nib;
        logic       fin;
    } pos_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + {4'd0, nib};
        else
            ch = CH_LOWER_A + {4'd0, nib} - 8'd10;
        return ch;
    endfunction

    // digit idx of an octet: 0 ones, 1 tens, 2 hundreds
    function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] idx);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [3:0]  o;
        logic [3:0]  d;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r    = 7'(v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0)));
        // reciprocal of ten, exact for r below one hundred
        prod = {8'd0, r} * 15'd205;
        t    = prod[14:11];
        o    = 4'(r - {3'd0, t} * 7'd10);
        case (idx)
            2'd2:    d = {2'd0, h};
            2'd1:    d = t;
            default: d = o;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] lead_hex(input logic [15:0] w);
        logic [1:0] n;
        if (w[15:12] != 4'd0)
            n = 2'd3;
        else if (w[11:8] != 4'd0)
            n = 2'd2;
        else if (w[7:4] != 4'd0)
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

    function automatic logic [1:0] lead_dec(input logic [7:0] v);
        logic [1:0] n;
        n = (v >= 8'd100) ? 2'd2 : ((v >= 8'd10) ? 2'd1 : 2'd0);
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/ip_address_to_text.sv =====
// ----------------------------------------------------------------------------
// ip_address_to_text
// renders an IPv4 or IPv6 address as ASCII text, one character per item
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   operation, addr_high, addr_low, buffer_size
//  out       out_valid / out_stall character, status, last
//
//  one shared text cursor walks the address one character a cycle, held by out_stall while emitting
//  IPv4: setup, the n text characters, then NUL
//  IPv6: zero-run scan over the groups, a length pass, then the n text characters
//  and NUL; unsupported family or zero size give a single error item
//  in_stall is high from accept until the NUL or error item is registered
//  out_stall holds the output register and, while emitting, freezes the cursor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ip_address_to_text
    import ipat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] addr_high,
    input  wire logic [63:0] addr_low,
    input  wire logic [6:0]  buffer_size,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       character,
    output logic [1:0]       status,
    output logic             last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_START,
        S_COUNT,
        S_EMIT
    } state_t;

    state_t       state_reg,  state_next;
    logic         v6_reg,     v6_next;
    logic [127:0] addr_reg,   addr_next;
    logic [6:0]   size_reg,   size_next;
    logic [6:0]   lim_reg,    lim_next;
    logic [5:0]   cnt_reg,    cnt_next;
    logic [1:0]   st_reg,     st_next;
    pos_t         pos_reg,    pos_next;
    logic [3:0]   run_reg,    run_next;
    logic [2:0]   rstart_reg, rstart_next;
    logic [3:0]   best_reg,   best_next;
    logic [2:0]   bstart_reg, bstart_next;
    logic         ov_reg,     ov_next;
    logic [7:0]   ch_reg,     ch_next;
    logic [1:0]   status_reg, status_next;
    logic         last_reg,   last_next;

    logic         out_free;
    logic [15:0]  grp_cur;
    logic [7:0]   oct_cur;
    logic [2:0]   g_inc;
    logic [15:0]  grp_inc;
    logic [7:0]   oct_inc;
    logic [3:0]   g_skip;
    logic [15:0]  grp_skip;
    pos_t         pos_first;
    pos_t         pos_step;
    logic [7:0]   cur_char;
    logic [3:0]   run_inc;
    logic [2:0]   run_from;

    // cursor entry into a group: the compressed run or its leading digit
    function automatic pos_t enter_pos(
        input logic [2:0]  gi,
        input logic [15:0] gv,
        input logic [7:0]  ov,
        input logic        v6,
        input logic [3:0]  best,
        input logic [2:0]  bstart
    );
        pos_t p;
        p.grp  = gi;
        p.fin  = 1'b0;
        p.nib  = 2'd0;
        p.kind = K_DIG;
        if (v6 && (best != 4'd0) && (gi == bstart))
            p.kind = (gi == 3'd0) ? K_ZA : K_ZB;
        else
            p.nib = v6 ? lead_hex(gv) : lead_dec(ov);
        return p;
    endfunction

    assign grp_cur  = addr_reg[(7 - pos_reg.grp) * 16 +: 16];
    assign oct_cur  = addr_reg[(3 - pos_reg.grp[1:0]) * 8 +: 8];
    assign g_inc    = pos_reg.grp + 3'd1;
    assign grp_inc  = addr_reg[(7 - g_inc) * 16 +: 16];
    assign oct_inc  = addr_reg[(3 - g_inc[1:0]) * 8 +: 8];
    assign g_skip   = {1'b0, pos_reg.grp} + best_reg;
    assign grp_skip = addr_reg[(7 - g_skip[2:0]) * 16 +: 16];

    assign pos_first = enter_pos(3'd0, addr_reg[127:112], addr_reg[31:24], v6_reg,
                                 best_reg, bstart_reg);

    // the shared text cursor: current character and where it goes next
    always_comb
    begin
        cur_char = CH_COLON;
        pos_step = pos_reg;
        unique case (pos_reg.kind)
            K_DIG:
            begin
                cur_char = v6_reg ? hex_char(grp_cur[pos_reg.nib * 4 +: 4])
                                  : CH_ZERO + {4'd0, dec_digit(oct_cur, pos_reg.nib)};
                if (pos_reg.nib != 2'd0)
                    pos_step.nib = pos_reg.nib - 2'd1;
                else if (v6_reg ? (pos_reg.grp == 3'd7) : (pos_reg.grp == 3'd3))
                    pos_step.fin = 1'b1;
                else
                    pos_step.kind = K_SEP;
            end
            K_SEP:
            begin
                cur_char = v6_reg ? CH_COLON : CH_DOT;
                pos_step = enter_pos(g_inc, grp_inc, oct_inc, v6_reg, best_reg, bstart_reg);
            end
            K_ZA:
            begin
                pos_step.kind = K_ZB;
            end
            K_ZB:
            begin
                // jump past the zero run; a run to the end closes the text
                if (g_skip[3])
                    pos_step.fin = 1'b1;
                else
                    pos_step = enter_pos(g_skip[2:0], grp_skip, oct_cur, v6_reg,
                                         best_reg, bstart_reg);
            end
        endcase
    end

    assign out_free = !ov_reg || !out_stall;
    assign run_inc  = run_reg + 4'd1;
    assign run_from = (run_reg == 4'd0) ? pos_reg.grp : rstart_reg;

    always_comb
    begin
        state_next  = state_reg;
        v6_next     = v6_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        lim_next    = lim_reg;
        cnt_next    = cnt_reg;
        st_next     = st_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        rstart_next = rstart_reg;
        best_next   = best_reg;
        bstart_next = bstart_reg;
        ov_next     = out_free ? 1'b0 : ov_reg;
        ch_next     = ch_reg;
        status_next = status_reg;
        last_next   = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next    = {addr_high, addr_low};
                    size_next    = buffer_size;
                    lim_next     = buffer_size - 7'd1;
                    v6_next      = (operation == OP_IPV6);
                    cnt_next     = 6'd0;
                    st_next      = ST_OK;
                    run_next     = 4'd0;
                    rstart_next  = 3'd0;
                    best_next    = 4'd0;
                    bstart_next  = 3'd0;
                    pos_next.grp = 3'd0;
                    pos_next.fin = 1'b0;
                    if ((operation != OP_IPV4) && (operation != OP_IPV6))
                    begin
                        st_next      = ST_UNSUP;
                        pos_next.fin = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else if (buffer_size == 7'd0)
                    begin
                        st_next      = ST_NOSPACE;
                        pos_next.fin = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else if (operation == OP_IPV6)
                        state_next = S_SCAN;
                    else
                        state_next = S_START;
                end
            end
            S_SCAN:
            begin
                // first longest run of zero groups, one group a cycle
                if (grp_cur == 16'd0)
                begin
                    run_next    = run_inc;
                    rstart_next = run_from;
                    if (run_inc > best_reg)
                    begin
                        best_next   = run_inc;
                        bstart_next = run_from;
                    end
                end
                else
                    run_next = 4'd0;
                if (pos_reg.grp == 3'd7)
                    state_next = S_START;
                else
                    pos_next.grp = g_inc;
            end
            S_START:
            begin
                pos_next   = pos_first;
                cnt_next   = 6'd0;
                state_next = v6_reg ? S_COUNT : S_EMIT;
            end
            S_COUNT:
            begin
                // length pass, the text must fit with its NUL
                cnt_next = cnt_reg + 6'd1;
                pos_next = pos_step;
                if (pos_step.fin)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_EMIT;
                    if (({1'b0, cnt_reg} + 7'd2) > size_reg)
                    begin
                        st_next      = ST_NOSPACE;
                        pos_next.fin = 1'b1;
                    end
                    else
                        pos_next = pos_first;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (pos_reg.fin || ({1'b0, cnt_reg} == lim_reg))
                    begin
                        ch_next     = CH_NUL;
                        status_next = st_reg;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ch_next     = cur_char;
                        status_next = ST_OK;
                        last_next   = 1'b0;
                        cnt_next    = cnt_reg + 6'd1;
                        pos_next    = pos_step;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            v6_reg     <= 1'b0;
            addr_reg   <= '0;
            size_reg   <= '0;
            lim_reg    <= '0;
            cnt_reg    <= '0;
            st_reg     <= ST_OK;
            pos_reg    <= '0;
            run_reg    <= '0;
            rstart_reg <= '0;
            best_reg   <= '0;
            bstart_reg <= '0;
            ov_reg     <= 1'b0;
            ch_reg     <= CH_NUL;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            v6_reg     <= v6_next;
            addr_reg   <= addr_next;
            size_reg   <= size_next;
            lim_reg    <= lim_next;
            cnt_reg    <= cnt_next;
            st_reg     <= st_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
            rstart_reg <= rstart_next;
            best_reg   <= best_next;
            bstart_reg <= bstart_next;
            ov_reg     <= ov_next;
            ch_reg     <= ch_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign character = ch_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== design/ipat_checker.sv =====
// ----------------------------------------------------------------------------
// ipat_checker
// port-level checks on ip_address_to_text, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ip_address_to_text_assert.svh"

module ipat_checker
    import ipat_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] character,
    input wire logic [1:0] status,
    input wire logic       last
);

    // a stalled result item holds
    `IPAT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(status) && $stable(last), "stalled result item changed")

    // an error is always a single closing item
    `IPAT_ASSERT_IMP(a_err_last, out_valid && (status != ST_OK), last && (character == CH_NUL), "error item not last or not NUL")

    // text characters are never NUL, the closing item always is
    `IPAT_ASSERT_IMP(a_text_nz, out_valid && !last, character != CH_NUL, "NUL inside text")
    `IPAT_ASSERT_IMP(a_last_nul, out_valid && last, character == CH_NUL, "closing item not NUL")

    // an accepted request keeps the block busy
    `IPAT_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall, "not busy after accept")

endmodule

bind ip_address_to_text ipat_checker u_ipat_checker (.*);

`default_nettype wire
